### hw/rtl/cpq_pkg.sv
// Shared types, constants and helper functions for the quad outline closest-point block.
`default_nettype none
package cpq_pkg;
	localparam int W = 32;          // wrapping datapath word
	localparam int CW = 16;         // coordinate field width
	localparam int DW = 17;         // edge delta width
	localparam int DIST_W = 17;     // per-edge squared distance width
	localparam int NEDGE = 4;
	localparam logic [DIST_W-1:0] NO_DIST = 17'h0FFFF;
	localparam logic [CW-1:0] NO_DIST16 = 16'hFFFF;
	localparam logic [DW-1:0] AXIS_LIMIT = 17'h00100;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [DW-1:0] dlt_t;
	typedef logic signed [W-1:0] word_t;

	// one edge with the query point
	typedef struct packed {
		crd_t x0;
		crd_t y0;
		crd_t x1;
		crd_t y1;
		crd_t px;
		crd_t py;
	} seg_t;

	typedef struct packed {
		crd_t x0;
		crd_t y0;
		crd_t x1;
		crd_t y1;
		crd_t px;
		crd_t py;
		dlt_t dx;
		dlt_t dy;
		logic dom_x;    // |dx| > |dy|
		logic vert;
		logic horz;
	} geo_t;

	typedef struct packed {
		geo_t g;
		word_t a;
	} ga_t;

	typedef struct packed {
		geo_t g;
		word_t a;
		word_t c;
	} gac_t;

	function automatic word_t wx(dlt_t d);
		return {{(W-DW){d[DW-1]}}, d};
	endfunction

	function automatic word_t wc(crd_t c);
		return {{(W-CW){c[CW-1]}}, c};
	endfunction

	function automatic logic [DW-1:0] absd(dlt_t d);
		return d[DW-1] ? -d : d;
	endfunction

	// dominant-axis view: u is the dominant axis, v the other one
	function automatic word_t du_f(geo_t g);
		return g.dom_x ? wx(g.dx) : wx(g.dy);
	endfunction

	function automatic word_t dv_f(geo_t g);
		return g.dom_x ? wx(g.dy) : wx(g.dx);
	endfunction

	function automatic word_t u0_f(geo_t g);
		return g.dom_x ? wc(g.x0) : wc(g.y0);
	endfunction

	function automatic word_t v0_f(geo_t g);
		return g.dom_x ? wc(g.y0) : wc(g.x0);
	endfunction

	function automatic word_t pu_f(geo_t g);
		return g.dom_x ? wc(g.px) : wc(g.py);
	endfunction

	function automatic word_t pv_f(geo_t g);
		return g.dom_x ? wc(g.py) : wc(g.px);
	endfunction
endpackage
`default_nettype wire

### hw/rtl/cpq_if.sv
// Query and result channel interfaces.
`default_nettype none
interface cpq_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] corner_ul_x;
	logic signed [15:0] corner_ul_y;
	logic signed [15:0] corner_ur_x;
	logic signed [15:0] corner_ur_y;
	logic signed [15:0] corner_ll_x;
	logic signed [15:0] corner_ll_y;
	logic signed [15:0] corner_lr_x;
	logic signed [15:0] corner_lr_y;
	modport source(output valid, point_x, point_y, corner_ul_x, corner_ul_y, corner_ur_x,
		corner_ur_y, corner_ll_x, corner_ll_y, corner_lr_x, corner_lr_y, input ready);
	modport sink(input valid, point_x, point_y, corner_ul_x, corner_ul_y, corner_ur_x,
		corner_ur_y, corner_ll_x, corner_ll_y, corner_lr_x, corner_lr_y, output ready);
endinterface

interface cpq_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] nearest_x;
	logic signed [15:0] nearest_y;
	logic [15:0] best_distance;
	logic found;
	modport source(output valid, nearest_x, nearest_y, best_distance, found, input ready);
	modport sink(input valid, nearest_x, nearest_y, best_distance, found, output ready);
endinterface
`default_nettype wire

### hw/rtl/closest_point_on_quad_outline.sv
// Closest point on a quadrilateral outline: top level with edge lanes and best-edge select.
//
// query channel: one transaction carries the query point and the four corners
// ul, ur, ll, lr. The edges ul-ur, ur-ll, ll-lr, lr-ul run in four parallel
// lanes; each lane has three chained 34-stage dividers (one quotient bit per
// stage), which set the depth.
// result channel: one transaction per query with nearest_x, nearest_y,
// best_distance and found. found is 0 (point 0, distance 65535) when no edge
// comes within a squared distance below 65535.
// Throughput: one query per cycle while the receiver does not stall; queries are independent.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// query.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
// COORD_BITS: inputs are sign-extended from bit COORD_BITS-1.
`default_nettype none
module closest_point_on_quad_outline #(
	parameter int COORD_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	cpq_in_if.sink   query,
	cpq_out_if.source result
);
	import cpq_pkg::*;

	localparam int SH = CW - COORD_BITS;

	function automatic crd_t sx(crd_t v);
		crd_t t;
		t = v << SH;
		return t >>> SH;
	endfunction

	logic adv;
	crd_t px, py;
	crd_t cx [NEDGE+1];
	crd_t cy [NEDGE+1];
	logic [NEDGE-1:0] e_vld;
	crd_t e_qx [NEDGE];
	crd_t e_qy [NEDGE];
	logic [DIST_W-1:0] e_d [NEDGE];

	logic vld_s11;
	crd_t bx_s11 [2];
	crd_t by_s11 [2];
	logic [DIST_W-1:0] bd_s11 [2];

	logic vld_s12;
	crd_t nx_s12, ny_s12;
	logic [CW-1:0] nd_s12;
	logic found_s12;

	logic sel_w, found_w;
	logic [DIST_W-1:0] d_w;

	assign adv = !vld_s12 || result.ready;
	assign query.ready = adv;

	assign px = sx(query.point_x);
	assign py = sx(query.point_y);
	assign cx[0] = sx(query.corner_ul_x);
	assign cy[0] = sx(query.corner_ul_y);
	assign cx[1] = sx(query.corner_ur_x);
	assign cy[1] = sx(query.corner_ur_y);
	assign cx[2] = sx(query.corner_ll_x);
	assign cy[2] = sx(query.corner_ll_y);
	assign cx[3] = sx(query.corner_lr_x);
	assign cy[3] = sx(query.corner_lr_y);
	assign cx[4] = cx[0];
	assign cy[4] = cy[0];

	for (genvar i = 0; i < NEDGE; i++) begin : g_edge
		seg_t seg;
		assign seg = '{x0: cx[i], y0: cy[i], x1: cx[i+1], y1: cy[i+1], px: px, py: py};
		cpq_edge u_edge (
			.clk(clk), .arst_n(arst_n), .en(adv), .vld_i(query.valid), .seg(seg),
			.vld_o(e_vld[i]), .qx(e_qx[i]), .qy(e_qy[i]), .sq_dist(e_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s11 <= e_vld[0];
			vld_s12 <= vld_s11;
		end
	end

	// pairwise pick; a tie keeps the earlier edge
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 2; j++) begin
				if (e_d[2*j+1] < e_d[2*j]) begin
					bx_s11[j] <= e_qx[2*j+1];
					by_s11[j] <= e_qy[2*j+1];
					bd_s11[j] <= e_d[2*j+1];
				end else begin
					bx_s11[j] <= e_qx[2*j];
					by_s11[j] <= e_qy[2*j];
					bd_s11[j] <= e_d[2*j];
				end
			end
		end
	end

	assign sel_w = bd_s11[1] < bd_s11[0];
	assign d_w = sel_w ? bd_s11[1] : bd_s11[0];
	assign found_w = d_w < NO_DIST;

	always_ff @(posedge clk) begin
		if (adv) begin
			found_s12 <= found_w;
			if (found_w) begin
				nx_s12 <= sel_w ? bx_s11[1] : bx_s11[0];
				ny_s12 <= sel_w ? by_s11[1] : by_s11[0];
				nd_s12 <= d_w[CW-1:0];
			end else begin
				nx_s12 <= '0;
				ny_s12 <= '0;
				nd_s12 <= NO_DIST16;
			end
		end
	end

	assign result.valid = vld_s12;
	assign result.nearest_x = nx_s12;
	assign result.nearest_y = ny_s12;
	assign result.best_distance = nd_s12;
	assign result.found = found_s12;

	a_nofind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |->
		result.best_distance == NO_DIST16 && result.nearest_x == '0 && result.nearest_y == '0)
		else $error("no-hit result carries a point or distance");

	a_find: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.found |-> result.best_distance != NO_DIST16)
		else $error("hit reported with saturated distance");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		e_vld == {NEDGE{e_vld[0]}})
		else $error("edge lanes out of step");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid && !result.ready)
		else $error("input stalled without an output stall");
endmodule
`default_nettype wire

### hw/rtl/cpq_div.sv
// Pipelined signed 32-bit divider, truncating, one quotient bit per stage.
`default_nettype none
module cpq_div #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  cpq_pkg::word_t num,
	input  cpq_pkg::word_t den,
	input  logic [PW-1:0] pay_i,
	output logic          vld_o,
	output cpq_pkg::word_t quo,
	output logic [PW-1:0] pay_o
);
	import cpq_pkg::*;

	logic [W:0]    vld_s;
	logic [W-1:0]  num_s [0:W];
	logic [W-1:0]  den_s [0:W];
	logic [W-1:0]  rem_s [1:W-1];
	logic          neg_s [0:W];
	logic          dz_s  [0:W];
	logic [PW-1:0] pay_s [0:W];
	logic          vld_os;
	word_t         quo_os;
	logic [PW-1:0] pay_os;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_os <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[W-1:0], vld_i};
			vld_os <= vld_s[W];
		end
	end

	// magnitudes and sign
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= num[W-1] ? -num : num;
			den_s[0] <= den[W-1] ? -den : den;
			neg_s[0] <= num[W-1] ^ den[W-1];
			dz_s[0] <= (den == '0);
			pay_s[0] <= pay_i;
		end
	end

	// restoring steps; the dividend register fills with quotient bits
	for (genvar k = 0; k < W; k++) begin : g_st
		logic [W:0] trial;
		logic [W:0] diff;
		if (k == 0) begin : g_first
			assign trial = {{W{1'b0}}, num_s[0][W-1]};
		end else begin : g_rest
			assign trial = {rem_s[k], num_s[k][W-1]};
		end
		assign diff = trial - {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= {num_s[k][W-2:0], ~diff[W]};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				dz_s[k+1] <= dz_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
		if (k < W-1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[W]) begin
				quo_os <= '0;
			end else begin
				quo_os <= neg_s[W] ? -num_s[W] : num_s[W];
			end
			pay_os <= pay_s[W];
		end
	end

	assign vld_o = vld_os;
	assign quo = quo_os;
	assign pay_o = pay_os;
endmodule
`default_nettype wire

### hw/rtl/cpq_edge.sv
// Closest point on one edge and its squared distance, fully pipelined.
`default_nettype none
module cpq_edge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  cpq_pkg::seg_t                 seg,
	output logic                          vld_o,
	output cpq_pkg::crd_t                 qx,
	output cpq_pkg::crd_t                 qy,
	output logic [cpq_pkg::DIST_W-1:0]    sq_dist
);
	import cpq_pkg::*;

	localparam int GW = $bits(geo_t);
	localparam int GAW = $bits(ga_t);
	localparam int GACW = $bits(gac_t);

	geo_t geo_w;
	dlt_t dx_w, dy_w;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_a, vld_c, vld_d;
	geo_t g_s1, g_s2, g_s3, g_s4, g_s5;
	word_t p1_s2, p2_s2;
	word_t a_s3, c_s3, sqx_s3, sqy_s3;
	word_t a_s4, m1_s4, sq_s4;
	word_t a_s5, m2_s5, sq_s5;
	ga_t ga_s6;
	word_t c2_s6;
	gac_t gac_s7;
	word_t m3_s7;
	geo_t g_s8;
	word_t ex_s8, ey_s8;
	crd_t qx_s9, qy_s9, px_s9, py_s9;
	crd_t qx_s10, qy_s10;
	logic [DIST_W-1:0] d_s10;

	word_t a_w, b_w, c2_w, q_w;
	logic [GW-1:0] pa_w;
	logic [GAW-1:0] pc_w;
	logic [GACW-1:0] pd_w;
	geo_t g_a;
	ga_t ga_c;
	gac_t gac_d;
	word_t ev_w, ex_w, ey_w;
	logic to_start, to_end;
	crd_t cx_w, cy_w;
	dlt_t ddx_w, ddy_w;
	logic [DW-1:0] ax_w, ay_w;
	logic [15:0] axx_w, ayy_w;
	logic [DIST_W-1:0] d_w;

	assign g_a = geo_t'(pa_w);
	assign ga_c = ga_t'(pc_w);
	assign gac_d = gac_t'(pd_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_a;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_c;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_d;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// s1: deltas and edge class
	assign dx_w = {seg.x1[CW-1], seg.x1} - {seg.x0[CW-1], seg.x0};
	assign dy_w = {seg.y1[CW-1], seg.y1} - {seg.y0[CW-1], seg.y0};
	always_comb begin
		geo_w.x0 = seg.x0;
		geo_w.y0 = seg.y0;
		geo_w.x1 = seg.x1;
		geo_w.y1 = seg.y1;
		geo_w.px = seg.px;
		geo_w.py = seg.py;
		geo_w.dx = dx_w;
		geo_w.dy = dy_w;
		geo_w.dom_x = absd(dx_w) > absd(dy_w);
		geo_w.vert = (dx_w == '0);
		geo_w.horz = (dy_w == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= geo_w;
			// s2: numerators of a and b
			g_s2 <= g_s1;
			p1_s2 <= u0_f(g_s1) * dv_f(g_s1);
			p2_s2 <= pu_f(g_s1) * du_f(g_s1);
		end
	end

	cpq_div #(.PW(GW)) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
		.num(p1_s2), .den(du_f(g_s2)), .pay_i(g_s2),
		.vld_o(vld_a), .quo(a_w), .pay_o(pa_w)
	);

	cpq_div #(.PW(1)) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
		.num(p2_s2), .den(dv_f(g_s2)), .pay_i(1'b0),
		.vld_o(), .quo(b_w), .pay_o()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s3 <= g_a;
			a_s3 <= a_w;
			c_s3 <= a_w + b_w - v0_f(g_a) + pv_f(g_a);
			sqx_s3 <= wx(g_a.dx) * wx(g_a.dx);
			sqy_s3 <= wx(g_a.dy) * wx(g_a.dy);
			g_s4 <= g_s3;
			a_s4 <= a_s3;
			m1_s4 <= c_s3 * dv_f(g_s3);
			sq_s4 <= sqx_s3 + sqy_s3;
			g_s5 <= g_s4;
			a_s5 <= a_s4;
			m2_s5 <= m1_s4 * du_f(g_s4);
			sq_s5 <= sq_s4;
		end
	end

	cpq_div #(.PW(GAW)) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s5),
		.num(m2_s5), .den(sq_s5), .pay_i({g_s5, a_s5}),
		.vld_o(vld_c), .quo(c2_w), .pay_o(pc_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ga_s6 <= ga_c;
			c2_s6 <= c2_w;
			gac_s7 <= {ga_s6.g, ga_s6.a, c2_s6};
			m3_s7 <= c2_s6 * dv_f(ga_s6.g);
		end
	end

	cpq_div #(.PW(GACW)) u_div_d (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s7),
		.num(m3_s7), .den(du_f(gac_s7.g)), .pay_i(gac_s7),
		.vld_o(vld_d), .quo(q_w), .pay_o(pd_w)
	);

	// s8: raw edge point, back in x/y order
	assign ev_w = q_w - gac_d.a + v0_f(gac_d.g);
	always_comb begin
		if (gac_d.g.vert) begin
			ex_w = wc(gac_d.g.x0);
			ey_w = wc(gac_d.g.py);
		end else if (gac_d.g.horz) begin
			ex_w = wc(gac_d.g.px);
			ey_w = wc(gac_d.g.y0);
		end else if (gac_d.g.dom_x) begin
			ex_w = gac_d.c;
			ey_w = ev_w;
		end else begin
			ex_w = ev_w;
			ey_w = gac_d.c;
		end
	end

	// s9: clamp to the endpoints along the dominant axis
	always_comb begin
		to_start = 1'b0;
		to_end = 1'b0;
		if (g_s8.dom_x) begin
			if (!g_s8.dx[DW-1]) begin
				to_start = ex_s8 < wc(g_s8.x0);
				to_end = !to_start && (ex_s8 > wc(g_s8.x1));
			end else begin
				to_start = ex_s8 > wc(g_s8.x0);
				to_end = !to_start && (ex_s8 < wc(g_s8.x1));
			end
		end else begin
			if (!g_s8.dy[DW-1] && g_s8.dy != '0) begin
				to_start = ey_s8 < wc(g_s8.y0);
				to_end = !to_start && (ey_s8 > wc(g_s8.y1));
			end else begin
				to_start = ey_s8 > wc(g_s8.y0);
				to_end = !to_start && (ey_s8 < wc(g_s8.y1));
			end
		end
		if (to_start) begin
			cx_w = g_s8.x0;
			cy_w = g_s8.y0;
		end else if (to_end) begin
			cx_w = g_s8.x1;
			cy_w = g_s8.y1;
		end else begin
			cx_w = ex_s8[CW-1:0];
			cy_w = ey_s8[CW-1:0];
		end
	end

	// s10: squared distance, saturated when an axis is far
	assign ddx_w = {qx_s9[CW-1], qx_s9} - {px_s9[CW-1], px_s9};
	assign ddy_w = {qy_s9[CW-1], qy_s9} - {py_s9[CW-1], py_s9};
	assign ax_w = absd(ddx_w);
	assign ay_w = absd(ddy_w);
	assign axx_w = ax_w[7:0] * ax_w[7:0];
	assign ayy_w = ay_w[7:0] * ay_w[7:0];
	always_comb begin
		if (ax_w >= AXIS_LIMIT || ay_w >= AXIS_LIMIT) begin
			d_w = NO_DIST;
		end else begin
			d_w = {1'b0, axx_w} + {1'b0, ayy_w};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s8 <= gac_d.g;
			ex_s8 <= ex_w;
			ey_s8 <= ey_w;
			qx_s9 <= cx_w;
			qy_s9 <= cy_w;
			px_s9 <= g_s8.px;
			py_s9 <= g_s8.py;
			qx_s10 <= qx_s9;
			qy_s10 <= qy_s9;
			d_s10 <= d_w;
		end
	end

	assign vld_o = vld_s10;
	assign qx = qx_s10;
	assign qy = qy_s10;
	assign sq_dist = d_s10;
endmodule
`default_nettype wire
